### hw/rtl/rms_vector_normalizer_macros.svh
// Assertion macros for the RMS vector normalizer.
// Used by the port checker; no other dependencies.
`ifndef RMS_VECTOR_NORMALIZER_MACROS_SVH
`define RMS_VECTOR_NORMALIZER_MACROS_SVH

// Implication checked on every rising edge outside reset
`define RVN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rvn assertion failed");

// Same check, but also evaluated while reset is held
`define RVN_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rvn assertion failed");

`endif

### hw/rtl/rvn_pkg.sv
// Shared types and constants for the RMS vector normalizer.
// No dependencies; used by every RTL file of the block.
package rvn_pkg;

  localparam int DefMaxLen = 64;
  localparam int VecLenW   = 7;
  localparam int EpsW      = 16;
  localparam int IdxW      = 6;
  localparam int ValW      = 16;
  localparam int CfgIdxW   = 2;
  localparam int SumW      = 37;
  localparam int DivSh     = 45;   // dividend / quotient shift width
  localparam int DivD      = 32;   // divisor width
  localparam int DivStW    = 6;
  localparam int MeanW     = 46;
  localparam int RadW      = 62;
  localparam int RootW     = 31;
  localparam int NumW      = 44;
  localparam int QW        = 17;   // element quotient bits

  localparam logic [CfgIdxW-1:0] CfgVecLen = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEps    = 2'd1;

  localparam logic ModeWeight = 1'b0;
  localparam logic ModeData   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MEAN, S_MEAN_W, S_ROOT, S_ROOT_W,
    S_RD, S_MUL, S_NUM, S_DIV, S_DIV_W, S_OUT
  } state_e;

  typedef struct packed {
    logic take;      // input word accepted
    logic mean_go;   // start sum / count divide
    logic sqrt_go;   // start root of mean plus eps
    logic elem_rd;   // read buffer and weight at current position
    logic elem_mul;  // register product
    logic elem_num;  // register dividend and overflow flag
    logic elem_go;   // start element divide
    logic out_load;  // load output word, advance position
    logic row_clr;   // clear sum, count, position
  } cmd_t;

  typedef struct packed {
    logic row_done;
    logic div_busy;
    logic sqrt_busy;
    logic skip_div;
    logic out_free;
    logic k_last;
  } sts_t;

endpackage

### hw/rtl/rms_vector_normalizer.sv
// Channel  | signals                    | content
// s_axis   | tvalid tready tdata tuser  | weight write or data element
// m_axis   | tvalid tready tdata tuser tlast | normalized element
// cfg      | valid ready index data     | vec_len (0), eps (1)
//
// A weight write is taken in idle; a data element is taken and then row-checked.
// A completed row of n elements then runs the mean divide and the root, then per
// element the setup states read, multiply and dividend, a divider start and wait
// (both skipped when the divide is skipped) and an output load, which waits while
// the output is stalled; input is held off during that pass.
// Reset clears row count, sum, position and control; memories are not cleared.
// Top level: RMS vector normalizer. Depends on rvn_pkg, rvn_ctrl, rvn_dpath.
module rms_vector_normalizer #(
  parameter int MAX_LEN = rvn_pkg::DefMaxLen
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [23:0]                 s_axis_tdata_i,  // index[5:0], sample_value[21:6]
  input  logic                        s_axis_tuser_i,  // mode
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [23:0]                 m_axis_tdata_o,  // norm_value[15:0], position[21:16]
  output logic                        m_axis_tuser_o,  // saturated
  output logic                        m_axis_tlast_o,  // last
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rvn_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rvn_pkg::EpsW-1:0]    cfg_data_i
);
  import rvn_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic signed [ValW-1:0] norm;
  logic [IdxW-1:0]        pos;

  assign cfg_ready_o = 1'b1;

  rvn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .mode_i     (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rvn_dpath #(.MAX_LEN(MAX_LEN)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_i      (s_axis_tuser_i),
    .idx_i       (s_axis_tdata_i[5:0]),
    .val_i       (s_axis_tdata_i[21:6]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .norm_o      (norm),
    .pos_o       (pos),
    .sat_o       (m_axis_tuser_o),
    .last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, pos, norm};
endmodule

### hw/rtl/rvn_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rvn_pkg for widths.
module rvn_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rvn_pkg::DivD:0]     rem0_i,
  input  logic [rvn_pkg::DivSh-1:0]  sh0_i,
  input  logic [rvn_pkg::DivD-1:0]   dvs_i,
  input  logic [rvn_pkg::DivStW-1:0] steps_i,
  output logic                       busy_o,
  output logic [rvn_pkg::DivSh-1:0]  quo_o
);
  import rvn_pkg::*;

  logic [DivD:0]     rem_q, rem_d, trial;
  logic [DivSh-1:0]  sh_q, sh_d;
  logic [DivD-1:0]   dvs_q;
  logic [DivStW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              fits;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial  = {rem_q[DivD-1:0], sh_q[DivSh-1]};
    fits   = trial >= {1'b0, dvs_q};
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = rem0_i;
      sh_d   = sh0_i;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? trial - {1'b0, dvs_q} : trial;
      sh_d   = {sh_q[DivSh-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      busy_d = cnt_q != DivStW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    if (start_i) dvs_q <= dvs_i;
  end

  assign busy_o = busy_q;
  assign quo_o  = sh_q;
endmodule

### hw/rtl/rvn_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on rvn_pkg for widths.
module rvn_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rvn_pkg::RadW-1:0]  rad_i,
  output logic                      busy_o,
  output logic [rvn_pkg::RootW-1:0] root_o
);
  import rvn_pkg::*;

  localparam int RemW = RootW + 4;
  localparam int CntW = $clog2(RootW + 1);

  logic [RemW-1:0]  rem_q, rem_d, trial;
  logic [RootW+1:0] tst;
  logic [RadW-1:0]  rad_q, rad_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             fits;

  // Bring down two radicand bits and test the next root bit
  always_comb begin
    trial  = {rem_q[RemW-3:0], rad_q[RadW-1:RadW-2]};
    tst    = {root_q, 2'b01};
    fits   = trial >= RemW'(tst);
    rem_d  = rem_q;
    rad_d  = rad_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      rad_d  = rad_i;
      root_d = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? trial - RemW'(tst) : trial;
      rad_d  = {rad_q[RadW-3:0], 2'b00};
      root_d = {root_q[RootW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      busy_d = cnt_q != CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    rad_q  <= rad_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;
endmodule

### hw/rtl/rvn_dpath.sv
// Datapath: registers, row and weight memories, sum of squares,
// divider and root units, element scaling and output register.
// Depends on rvn_pkg, rvn_div and rvn_sqrt.
module rvn_dpath #(
  parameter int MAX_LEN = rvn_pkg::DefMaxLen
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rvn_pkg::cmd_t               cmd_i,
  output rvn_pkg::sts_t               sts_o,
  input  logic                        cfg_valid_i,
  input  logic [rvn_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rvn_pkg::EpsW-1:0]    cfg_data_i,
  input  logic                        mode_i,
  input  logic [rvn_pkg::IdxW-1:0]    idx_i,
  input  logic signed [rvn_pkg::ValW-1:0] val_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic signed [rvn_pkg::ValW-1:0] norm_o,
  output logic [rvn_pkg::IdxW-1:0]    pos_o,
  output logic                        sat_o,
  output logic                        last_o
);
  import rvn_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  // Configuration registers
  logic [VecLenW-1:0] vec_len_q;
  logic [EpsW-1:0]    eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_len_q <= VecLenW'(64);
      eps_q     <= EpsW'(17);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgVecLen) vec_len_q <= cfg_data_i[VecLenW-1:0];
      if (cfg_index_i == CfgEps)    eps_q     <= cfg_data_i;
    end
  end

  // Row bookkeeping
  logic [SumW-1:0] sum_q;
  logic [CW-1:0]   count_q, k_q;
  logic [31:0]     square;
  logic            take_data, take_wt, room;
  logic [VecLenW-1:0] len_c;

  assign take_data = cmd_i.take && (mode_i == ModeData);
  assign take_wt   = cmd_i.take && (mode_i == ModeWeight) &&
                     ({1'b0, idx_i} < (IdxW + 1)'(MAX_LEN));
  assign room      = count_q < CW'(MAX_LEN);
  assign square    = 32'(val_i * val_i);

  always_comb begin
    if (vec_len_q == '0)                       len_c = VecLenW'(1);
    else if (vec_len_q > VecLenW'(MAX_LEN))    len_c = VecLenW'(MAX_LEN);
    else                                       len_c = vec_len_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      k_q     <= '0;
    end else if (cmd_i.row_clr) begin
      sum_q   <= '0;
      count_q <= '0;
      k_q     <= '0;
    end else begin
      if (take_data && room) begin
        sum_q   <= sum_q + SumW'(square);
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.out_load) k_q <= k_q + 1'b1;
    end
  end

  // Memories: one write port, one registered read port each
  logic signed [ValW-1:0] rbuf [MAX_LEN];
  logic signed [ValW-1:0] wmem [MAX_LEN];
  logic signed [ValW-1:0] x_q, w_q;

  always_ff @(posedge clk_i) begin
    if (take_data && room) rbuf[count_q[AW-1:0]] <= val_i;
    if (cmd_i.elem_rd)     x_q <= rbuf[k_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (take_wt)       wmem[idx_i[AW-1:0]] <= val_i;
    if (cmd_i.elem_rd) w_q <= wmem[k_q[AW-1:0]];
  end

  // Shared divider: mean square, then one quotient per element unless the divide is skipped
  logic [DivD:0]     rem0;
  logic [DivSh-1:0]  sh0, quo;
  logic [DivD-1:0]   dvs;
  logic [DivStW-1:0] steps;
  logic              div_busy;
  logic [RootW-1:0]  root;
  logic [NumW-1:0]   num_q;

  always_comb begin
    if (cmd_i.mean_go) begin
      rem0  = '0;
      sh0   = {sum_q, 8'b0};
      dvs   = DivD'(count_q);
      steps = DivStW'(DivSh);
    end else begin
      rem0  = (DivD + 1)'(num_q[NumW-1:QW]);
      sh0   = {num_q[QW-1:0], (DivSh - QW)'(0)};
      dvs   = {root, 1'b0};
      steps = DivStW'(QW);
    end
  end

  rvn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mean_go || cmd_i.elem_go),
    .rem0_i  (rem0),
    .sh0_i   (sh0),
    .dvs_i   (dvs),
    .steps_i (steps),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // Root of mean square plus eps
  logic [MeanW-1:0] mean;
  logic             sqrt_busy;

  assign mean = MeanW'(quo) + MeanW'(eps_q);

  rvn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_go),
    .rad_i   ({mean, 16'b0}),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  // Element scaling: product, magnitude, rounded dividend
  logic signed [31:0] p_q;
  logic [30:0]        mag;
  logic [NumW-1:0]    num_d;
  logic               neg_q, ovf_q;

  assign mag   = p_q[31] ? 31'(-p_q) : 31'(p_q);
  assign num_d = NumW'({mag, 13'b0}) + NumW'(root);

  always_ff @(posedge clk_i) begin
    if (cmd_i.elem_mul) p_q <= x_q * w_q;
    if (cmd_i.elem_num) begin
      num_q <= num_d;
      neg_q <= p_q[31];
      ovf_q <= {5'b0, num_d} >= {root, 1'b0, QW'(0)};
    end
  end

  // Saturate and load the output word
  logic [QW-1:0]   q;
  logic [ValW-1:0] res;
  logic            sat, out_valid_q;

  always_comb begin
    q   = quo[QW-1:0];
    sat = 1'b0;
    res = '0;
    if (root == '0) begin
      res = '0;
    end else if (neg_q) begin
      if (ovf_q || q > QW'(32768)) begin
        sat = 1'b1;
        res = 16'h8000;
      end else begin
        res = ValW'(-q);
      end
    end else begin
      if (ovf_q || q > QW'(32767)) begin
        sat = 1'b1;
        res = 16'h7fff;
      end else begin
        res = ValW'(q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)             out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i)    out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      norm_o <= res;
      pos_o  <= IdxW'(k_q);
      sat_o  <= sat;
      last_o <= sts_o.k_last;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  assign sts_o.row_done  = VecLenW'(count_q) >= len_c;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.sqrt_busy = sqrt_busy;
  assign sts_o.skip_div  = ovf_q || (root == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.k_last    = CW'(k_q + 1'b1) == count_q;
endmodule

### hw/rtl/rvn_ctrl.sv
// Controller state machine: sequences input, mean, root and the
// per-element output pass. Depends on rvn_pkg.
module rvn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          mode_i,
  output logic          in_ready_o,
  input  rvn_pkg::sts_t sts_i,
  output rvn_pkg::cmd_t cmd_o
);
  import rvn_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (mode_i == ModeData) state_d = S_CHECK;
        end
      end
      S_CHECK:  state_d = sts_i.row_done ? S_MEAN : S_IDLE;
      S_MEAN: begin
        cmd_o.mean_go = 1'b1;
        state_d = S_MEAN_W;
      end
      S_MEAN_W: if (!sts_i.div_busy) state_d = S_ROOT;
      S_ROOT: begin
        cmd_o.sqrt_go = 1'b1;
        state_d = S_ROOT_W;
      end
      S_ROOT_W: if (!sts_i.sqrt_busy) state_d = S_RD;
      S_RD: begin
        cmd_o.elem_rd = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.elem_mul = 1'b1;
        state_d = S_NUM;
      end
      S_NUM: begin
        cmd_o.elem_num = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.skip_div) begin
          state_d = S_OUT;
        end else begin
          cmd_o.elem_go = 1'b1;
          state_d = S_DIV_W;
        end
      end
      S_DIV_W: if (!sts_i.div_busy) state_d = S_OUT;
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.k_last) begin
            cmd_o.row_clr = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

### hw/rtl/rvn_checker.sv
// Port checker for the RMS vector normalizer, bound to the top level.
// Depends on rvn_pkg and the assertion macro header.
`include "rms_vector_normalizer_macros.svh"

module rvn_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic [23:0]                 s_axis_tdata_i,
  input logic                        s_axis_tuser_i,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [23:0]                 m_axis_tdata_o,
  input logic                        m_axis_tuser_o,
  input logic                        m_axis_tlast_o,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [rvn_pkg::CfgIdxW-1:0] cfg_index_i,
  input logic [rvn_pkg::EpsW-1:0]    cfg_data_i
);
  import rvn_pkg::*;

  // Hold a stalled output word
  `RVN_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // A clipped word carries one of the two range limits
  `RVN_ASSERT(a_sat_limit, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[15:0] == 16'h8000 || m_axis_tdata_o[15:0] == 16'h7fff)

  // A data word is followed by a row-completion check cycle
  `RVN_ASSERT(a_data_gap, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == ModeData |=> !s_axis_tready_o)

  // Configuration is always taken
  `RVN_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_ready_o)
endmodule

bind rms_vector_normalizer rvn_checker u_rvn_checker (.*);

### tb/rms_vector_normalizer_test.sv
// Testbench for rms_vector_normalizer: stream weights and elements, predict
// each normalized row in a scoreboard class and compare words as they leave.
// Depends on rvn_pkg and the rms_vector_normalizer RTL.
module rms_vector_normalizer_test;
  import rvn_pkg::*;

  typedef struct {
    logic signed [15:0] norm;
    logic [5:0]         pos;
    logic               sat;
    logic               last;
  } norm_word_t;

  // Predicts normalized rows and holds the words still owed by the block
  class row_scoreboard;
    logic signed [15:0] weights[64];
    logic signed [15:0] row[64];
    longint unsigned    sq_sum;
    int unsigned        count;
    logic [6:0]         len_reg;
    logic [15:0]        eps_reg;
    norm_word_t         owed[$];
    int                 errors;

    function void reset_state();
      len_reg = 7'd64;
      eps_reg = 16'd17;
      sq_sum  = 0;
      count   = 0;
      errors  = 0;
      foreach (weights[i]) weights[i] = '0;
      owed.delete();
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      if (idx == CfgVecLen) len_reg = data[6:0];
      else if (idx == CfgEps) eps_reg = data;
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Note an accepted input word; queue the row when it completes
    function void note_input(logic mode, logic [5:0] idx, logic signed [15:0] val);
      int unsigned     lim;
      longint unsigned mean_sq;
      longint unsigned root;
      longint signed   prod;
      longint unsigned mag;
      longint unsigned quo;
      norm_word_t      w;
      if (mode == ModeWeight) begin
        weights[idx] = val;
        return;
      end
      if (count < 64) begin
        row[count] = val;
        sq_sum += longint'(val) * longint'(val);
        count++;
      end
      lim = (len_reg == 0) ? 1 : (len_reg > 64) ? 64 : len_reg;
      if (count < lim) return;
      mean_sq = (sq_sum << 8) / count + eps_reg;
      root    = int_root(mean_sq << 16);
      for (int k = 0; k < count; k++) begin
        prod = longint'(row[k]) * longint'(weights[k]);
        mag  = (prod < 0) ? -prod : prod;
        quo  = (root != 0) ? ((mag << 13) + root) / (root << 1) : 0;
        w.sat = 1'b0;
        if (prod < 0) begin
          if (quo > 32768) begin
            quo = 32768;
            w.sat = 1'b1;
          end
          w.norm = 16'(-quo);
        end else begin
          if (quo > 32767) begin
            quo = 32767;
            w.sat = 1'b1;
          end
          w.norm = 16'(quo);
        end
        w.pos  = 6'(k);
        w.last = (k + 1 == count);
        owed.push_back(w);
      end
      sq_sum = 0;
      count  = 0;
    endfunction

    // Compare one output word with the oldest owed word
    function void check_word(logic signed [15:0] norm, logic [5:0] pos, logic sat,
                             logic last);
      norm_word_t e;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: norm %0d pos %0d", norm, pos);
        return;
      end
      e = owed.pop_front();
      if (e.norm !== norm || e.pos !== pos || e.sat !== sat || e.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("word mismatch: exp norm %0d pos %0d sat %0b last %0b, got %0d %0d %0b %0b",
                   e.norm, e.pos, e.sat, e.last, norm, pos, sat, last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  row_scoreboard sb = new();
  int burst_left = 0;
  int data_sent = 0;
  int stall_kind = 0;

  rms_vector_normalizer i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: check accepted words, stall on a pattern that changes over time
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_word(m_axis_tdata_o[15:0], m_axis_tdata_o[21:16], m_axis_tuser_o,
                    m_axis_tlast_o);
    if ($urandom_range(0, 299) == 0) stall_kind <= $urandom_range(0, 3);
    case (stall_kind)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= $urandom_range(0, 1);
      2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Send one word; bursts of random length, usually separated by random gaps
  task automatic send_word(logic mode, logic [5:0] idx, logic [15:0] val);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= {2'b00, val, idx};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_input(mode, idx, val);
    if (mode == ModeData) data_sent++;
  endtask

  task automatic send_data(logic [15:0] val);
    send_word(ModeData, 6'($urandom_range(0, 63)), val);
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      3: return 16'(int'($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom());
    endcase
  endfunction

  // Hold until every owed word is out, then let the block settle
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    int n;
    sb.reset_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every weight, extremes at the front
    send_word(ModeWeight, 6'd0, 16'h7FFF);
    send_word(ModeWeight, 6'd1, 16'h8000);
    send_word(ModeWeight, 6'd2, 16'h0000);
    send_word(ModeWeight, 6'd3, 16'h0100);
    send_word(ModeWeight, 6'd4, 16'hFFFF);
    for (int i = 5; i < 64; i++) send_word(ModeWeight, 6'(i), rand_value());
    drain();

    // Zero root: all-zero row with eps zero
    write_reg(CfgVecLen, 16'd2);
    write_reg(CfgEps, 16'd0);
    send_data(16'h0000);
    send_data(16'h0000);
    // Extremes produce clipping
    send_data(16'h7FFF);
    send_data(16'h0001);
    send_data(16'h8000);
    send_data(16'h0001);
    drain();

    // Length zero acts as one; largest eps
    write_reg(CfgVecLen, 16'd0);
    write_reg(CfgEps, 16'hFFFF);
    send_data(16'h8000);
    send_data(16'h0001);
    drain();

    // Length lowered mid-row, with a weight write inside the row
    write_reg(CfgVecLen, 16'd8);
    for (int i = 0; i < 4; i++) send_data(rand_value());
    send_word(ModeWeight, 6'd5, 16'h0200);
    send_data(rand_value());
    drain();
    write_reg(CfgVecLen, 16'd3);
    send_data(rand_value());
    drain();

    // Length above the maximum acts as the maximum
    write_reg(CfgVecLen, 16'd127);
    write_reg(CfgEps, 16'd17);
    for (int i = 0; i < 64; i++) send_data(rand_value());
    drain();

    // Random phases: mostly short rows, some full ones
    while (data_sent < 170) begin
      case ($urandom_range(0, 7))
        0: write_reg(CfgVecLen, 16'd64);
        1: write_reg(CfgVecLen, 16'd1);
        2: write_reg(CfgVecLen, 16'($urandom_range(65, 127)));
        default: write_reg(CfgVecLen, 16'($urandom_range(2, 12)));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CfgEps, 16'd0);
        1: write_reg(CfgEps, 16'hFFFF);
        default: write_reg(CfgEps, 16'($urandom()));
      endcase
      n = $urandom_range(8, 40);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) send_word(ModeWeight, 6'($urandom()), rand_value());
        else send_data(rand_value());
      end
      drain();
    end

    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/rvn_pkg.sv
hw/rtl/rvn_div.sv
hw/rtl/rvn_sqrt.sv
hw/rtl/rvn_dpath.sv
hw/rtl/rvn_ctrl.sv
hw/rtl/rms_vector_normalizer.sv
hw/rtl/rvn_checker.sv
tb/rms_vector_normalizer_test.sv
